>>> hw/rtl/tzrt_pkg.sv
// ----------------------------------------------------------------------------
// tzrt_pkg
// Shared types, codes and constants of the two-finger zoom and rotate tracker.
// ----------------------------------------------------------------------------
package tzrt_pkg;

    localparam int TOUCH_SLOTS_DEF = 8;
    localparam int COORD_BITS_DEF  = 12;

    localparam int DRAG_W = 3;
    localparam int SEP_W  = 25;
    localparam logic [SEP_W-1:0] SEP_RESET = 25'd40000;

    localparam int KIND_W = 3;
    localparam int ZOOM_W = 16;
    localparam int ROT_W  = 16;
    localparam int ANG_W  = 21;
    localparam int CORDIC_STEPS = 16;

    localparam logic [KIND_W-1:0] EV_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] EV_UPD   = 3'd1;
    localparam logic [KIND_W-1:0] EV_DONE  = 3'd2;
    localparam logic [KIND_W-1:0] EV_CLAIM = 3'd3;
    localparam logic [KIND_W-1:0] EV_PAIR  = 3'd4;

    typedef logic [1:0] t_phase;
    localparam t_phase PH_NULL = 2'd0;
    localparam t_phase PH_RUN  = 2'd1;
    localparam t_phase PH_DONE = 2'd2;

    localparam logic signed [ANG_W-1:0] PI_Q16 = 21'sd205887;

    typedef struct packed {
        logic              in_range;
        logic              ended;
        logic [DRAG_W-1:0] drag_index;
    } t_cls;

    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [3:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            4'd0:    v = 21'sd51472;
            4'd1:    v = 21'sd30386;
            4'd2:    v = 21'sd16055;
            4'd3:    v = 21'sd8150;
            4'd4:    v = 21'sd4091;
            4'd5:    v = 21'sd2047;
            4'd6:    v = 21'sd1024;
            4'd7:    v = 21'sd512;
            4'd8:    v = 21'sd256;
            4'd9:    v = 21'sd128;
            4'd10:   v = 21'sd64;
            4'd11:   v = 21'sd32;
            4'd12:   v = 21'sd16;
            4'd13:   v = 21'sd8;
            4'd14:   v = 21'sd4;
            default: v = 21'sd2;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/tzrt_ram.sv
// ----------------------------------------------------------------------------
// tzrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tzrt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/tzrt_front.sv
// ----------------------------------------------------------------------------
// tzrt_front
// Accepts drag reports, checks the drag index range and packs the request.
// ----------------------------------------------------------------------------
module tzrt_front #(
    parameter int TOUCH_SLOTS = tzrt_pkg::TOUCH_SLOTS_DEF,
    parameter int COORD_BITS  = tzrt_pkg::COORD_BITS_DEF
) (
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [tzrt_pkg::DRAG_W-1:0] i_drag_index,
    input  logic                        i_drag_ended,
    input  logic [COORD_BITS-1:0]       i_start_x,
    input  logic [COORD_BITS-1:0]       i_start_y,
    input  logic [COORD_BITS-1:0]       i_cur_x,
    input  logic [COORD_BITS-1:0]       i_cur_y,
    input  logic                        i_full,
    output logic                        o_push,
    output tzrt_pkg::t_cls              o_cls,
    output logic [4*COORD_BITS-1:0]     o_pos
);

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    always_comb begin
        o_cls.in_range   = (int'(i_drag_index) < TOUCH_SLOTS);
        o_cls.ended      = i_drag_ended;
        o_cls.drag_index = i_drag_index;
        o_pos            = {i_start_x, i_start_y, i_cur_x, i_cur_y};
    end

endmodule

>>> hw/rtl/tzrt_queue.sv
// ----------------------------------------------------------------------------
// tzrt_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module tzrt_queue #(
    parameter int WIDTH = 53
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

>>> hw/rtl/tzrt_cordic.sv
// ----------------------------------------------------------------------------
// tzrt_cordic
// Iterative CORDIC vectoring unit, one step per cycle, Q.16 radian angle.
// ----------------------------------------------------------------------------
module tzrt_cordic #(
    parameter int IN_W = tzrt_pkg::COORD_BITS_DEF + 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [IN_W-1:0]            i_x,
    input  logic signed [IN_W-1:0]            i_y,
    output logic                              o_done,
    output logic signed [tzrt_pkg::ANG_W-1:0] o_angle
);

    localparam int CW = IN_W + 10;

    logic                              r_busy;
    logic                              r_done;
    logic [3:0]                        r_i;
    logic signed [CW-1:0]              r_x;
    logic signed [CW-1:0]              r_y;
    logic signed [tzrt_pkg::ANG_W-1:0] r_z;

    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    always_comb begin
        xe = CW'(i_x) <<< 8;
        ye = CW'(i_y) <<< 8;
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_i    <= 4'd0;
                    if (xe < 0) begin
                        r_x <= -xe;
                        r_y <= -ye;
                        r_z <= (i_y >= 0) ? tzrt_pkg::PI_Q16 : -tzrt_pkg::PI_Q16;
                    end else begin
                        r_x <= xe;
                        r_y <= ye;
                        r_z <= '0;
                    end
                end
            end else begin
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + tzrt_pkg::atan_q16(r_i);
                end else if (r_y < 0) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - tzrt_pkg::atan_q16(r_i);
                end
                if (r_i == 4'(tzrt_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 4'd1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_z;

endmodule

>>> hw/rtl/tzrt_back.sv
// ----------------------------------------------------------------------------
// tzrt_back
// Executes requests: slot table scan, pairing, zoom and rotation update.
// ----------------------------------------------------------------------------
module tzrt_back #(
    parameter int TOUCH_SLOTS = tzrt_pkg::TOUCH_SLOTS_DEF,
    parameter int COORD_BITS  = tzrt_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tzrt_pkg::SEP_W-1:0]   i_cfg_data,
    input  logic                         i_empty,
    input  tzrt_pkg::t_cls               i_cls,
    input  logic [4*COORD_BITS-1:0]      i_pos,
    output logic                         o_pop,
    output logic                         o_valid,
    output logic [2:0]                   o_slot_index,
    output logic [tzrt_pkg::KIND_W-1:0]  o_event_kind,
    output logic [tzrt_pkg::ZOOM_W-1:0]  o_zoom_value,
    output logic signed [tzrt_pkg::ROT_W-1:0] o_rotate_value,
    output logic                         o_degenerate
);

    localparam int SLOT_W = $clog2(TOUCH_SLOTS);
    localparam int POS_W  = 4 * COORD_BITS;
    localparam int D_W    = COORD_BITS + 1;
    localparam int M_W    = 2 * COORD_BITS + 1;
    localparam int Q_W    = M_W + 16;
    localparam int SQ_W   = Q_W + (Q_W % 2);
    localparam int R_W    = SQ_W / 2;
    localparam int CNT_W  = $clog2(Q_W);
    localparam int DF_W   = tzrt_pkg::ANG_W + 2;
    localparam int ZW     = tzrt_pkg::ZOOM_W;
    localparam int DW     = tzrt_pkg::DRAG_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN1 = 4'd1;
    localparam logic [3:0] S_SCAN2 = 4'd2;
    localparam logic [3:0] S_RDA   = 4'd3;
    localparam logic [3:0] S_RDB   = 4'd4;
    localparam logic [3:0] S_DRD   = 4'd5;
    localparam logic [3:0] S_SQM   = 4'd6;
    localparam logic [3:0] S_SQA   = 4'd7;
    localparam logic [3:0] S_DCMP  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_SQRT  = 4'd10;
    localparam logic [3:0] S_CST1  = 4'd11;
    localparam logic [3:0] S_CW1   = 4'd12;
    localparam logic [3:0] S_CST0  = 4'd13;
    localparam logic [3:0] S_CW0   = 4'd14;

    localparam logic signed [DF_W-1:0] ROT_HI = DF_W'(32767);
    localparam logic signed [DF_W-1:0] ROT_LO = -DF_W'(32768);

    logic [3:0]                    r_state;
    logic [SLOT_W-1:0]             r_slot;
    logic [DW-1:0]                 r_di;
    logic                          r_ended;
    logic                          r_upd;
    logic [COORD_BITS-1:0]         r_cx;
    logic [COORD_BITS-1:0]         r_cy;
    logic [POS_W-1:0]              r_pa;
    logic signed [D_W-1:0]         r_dv [4];
    logic [1:0]                    r_sqi;
    logic [M_W-1:0]                r_prod;
    logic [M_W-1:0]                r_m0;
    logic [M_W-1:0]                r_mt;
    logic [M_W-1:0]                r_rem;
    logic [Q_W-1:0]                r_quo;
    logic [CNT_W-1:0]              r_cnt;
    logic [SQ_W-1:0]               r_sqv;
    logic [R_W-1:0]                r_root;
    logic [R_W-1:0]                r_srem;
    logic [ZW-1:0]                 r_nzoom;
    logic                          r_ndeg;
    logic signed [tzrt_pkg::ANG_W-1:0] r_at;
    logic [tzrt_pkg::SEP_W-1:0]    r_sep;

    tzrt_pkg::t_phase              r_phase [TOUCH_SLOTS];
    logic                          r_has1  [TOUCH_SLOTS];
    logic                          r_has2  [TOUCH_SLOTS];
    logic [DW-1:0]                 r_link1 [TOUCH_SLOTS];
    logic [DW-1:0]                 r_link2 [TOUCH_SLOTS];
    logic [ZW-1:0]                 r_zoom  [TOUCH_SLOTS];
    logic signed [tzrt_pkg::ROT_W-1:0] r_rot [TOUCH_SLOTS];
    logic                          r_degen [TOUCH_SLOTS];

    logic                          r_ov;
    logic [2:0]                    r_oslot;
    logic [tzrt_pkg::KIND_W-1:0]   r_okind;
    logic [ZW-1:0]                 r_ozoom;
    logic signed [tzrt_pkg::ROT_W-1:0] r_orot;
    logic                          r_odeg;

    logic [SLOT_W-1:0]             rd_addr;
    logic [POS_W-1:0]              rd_data;
    logic                          ram_we;
    logic                          hit;
    logic                          last_slot;
    logic signed [2*D_W-1:0]       sq_full;
    logic [M_W-1:0]                acc_sum;
    logic [M_W:0]                  div_sh;
    logic                          div_ge;
    logic [Q_W-1:0]                quo_next;
    logic [R_W+1:0]                sq_rem2;
    logic [R_W+1:0]                sq_trial;
    logic                          sq_ge;
    logic [R_W-1:0]                root_next;
    logic                          cor_start;
    logic signed [D_W-1:0]         cor_x;
    logic signed [D_W-1:0]         cor_y;
    logic                          cor_done;
    logic signed [tzrt_pkg::ANG_W-1:0] cor_angle;
    logic signed [DF_W-1:0]        rot_diff;
    logic signed [DF_W-1:0]        rot_sh;
    logic signed [tzrt_pkg::ROT_W-1:0] rot_new;

    logic [COORD_BITS-1:0] ra_sx, ra_sy, ra_cx, ra_cy;
    logic [COORD_BITS-1:0] rb_sx, rb_sy, rb_cx, rb_cy;

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign ram_we = o_pop && i_cls.in_range;

    tzrt_ram #(
        .WIDTH (POS_W),
        .DEPTH (TOUCH_SLOTS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (SLOT_W'(i_cls.drag_index)),
        .i_wdata (i_pos),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    tzrt_cordic #(
        .IN_W (D_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_x     (cor_x),
        .i_y     (cor_y),
        .o_done  (cor_done),
        .o_angle (cor_angle)
    );

    always_comb begin
        case (r_state)
            S_SCAN1: rd_addr = SLOT_W'(r_link1[r_slot]);
            S_SCAN2: rd_addr = SLOT_W'(r_link1[r_slot]);
            S_RDA:   rd_addr = SLOT_W'(r_link2[r_slot]);
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        {ra_sx, ra_sy, ra_cx, ra_cy} = r_pa;
        {rb_sx, rb_sy, rb_cx, rb_cy} = rd_data;
        hit = (r_phase[r_slot] == tzrt_pkg::PH_RUN) &&
              ((r_has1[r_slot] && (r_link1[r_slot] == r_di)) ||
               (r_has2[r_slot] && (r_link2[r_slot] == r_di)));
        last_slot = (r_slot == SLOT_W'(TOUCH_SLOTS - 1));

        sq_full = r_dv[r_sqi] * r_dv[r_sqi];
        acc_sum = r_mt + r_prod;

        div_sh   = {r_rem, r_quo[Q_W-1]};
        div_ge   = (div_sh >= {1'b0, r_m0});
        quo_next = {r_quo[Q_W-2:0], div_ge};

        sq_rem2   = {r_srem, r_sqv[SQ_W-1 -: 2]};
        sq_trial  = {r_root, 2'b01};
        sq_ge     = (sq_rem2 >= sq_trial);
        root_next = {r_root[R_W-2:0], sq_ge};

        cor_start = (r_state == S_CST1) || (r_state == S_CST0);
        cor_x     = (r_state == S_CST1) ? r_dv[2] : r_dv[0];
        cor_y     = (r_state == S_CST1) ? r_dv[3] : r_dv[1];

        rot_diff = DF_W'(r_at) - DF_W'(cor_angle) + DF_W'(8);
        rot_sh   = rot_diff >>> 4;
        if (rot_sh > ROT_HI) begin
            rot_new = 16'sh7FFF;
        end else if (rot_sh < ROT_LO) begin
            rot_new = -16'sh8000;
        end else begin
            rot_new = rot_sh[tzrt_pkg::ROT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_sep   <= tzrt_pkg::SEP_RESET;
            r_ov    <= 1'b0;
            for (int k = 0; k < TOUCH_SLOTS; k++) begin
                r_phase[k] <= tzrt_pkg::PH_NULL;
                r_has1[k]  <= 1'b0;
                r_has2[k]  <= 1'b0;
                r_link1[k] <= '0;
                r_link2[k] <= '0;
                r_zoom[k]  <= '0;
                r_rot[k]   <= '0;
                r_degen[k] <= 1'b0;
            end
        end else begin
            r_ov <= 1'b0;
            if (i_cfg_we) begin
                r_sep <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_di    <= i_cls.drag_index;
                        r_ended <= i_cls.ended;
                        r_cx    <= i_pos[2*COORD_BITS-1 -: COORD_BITS];
                        r_cy    <= i_pos[COORD_BITS-1:0];
                        r_slot  <= '0;
                        if (i_cls.in_range) begin
                            r_state <= S_SCAN1;
                        end else begin
                            r_ov    <= 1'b1;
                            r_oslot <= '0;
                            r_okind <= tzrt_pkg::EV_NONE;
                            r_ozoom <= '0;
                            r_orot  <= '0;
                            r_odeg  <= 1'b0;
                        end
                    end
                end
                S_SCAN1: begin
                    if (hit) begin
                        if (r_ended) begin
                            r_phase[r_slot] <= tzrt_pkg::PH_DONE;
                            r_has1[r_slot]  <= 1'b0;
                            r_has2[r_slot]  <= 1'b0;
                            r_link1[r_slot] <= '0;
                            r_link2[r_slot] <= '0;
                            r_ov    <= 1'b1;
                            r_oslot <= 3'(r_slot);
                            r_okind <= tzrt_pkg::EV_DONE;
                            r_ozoom <= r_zoom[r_slot];
                            r_orot  <= r_rot[r_slot];
                            r_odeg  <= r_degen[r_slot];
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RDA;
                        end
                    end else if (last_slot) begin
                        if (r_ended) begin
                            r_ov    <= 1'b1;
                            r_oslot <= '0;
                            r_okind <= tzrt_pkg::EV_NONE;
                            r_ozoom <= '0;
                            r_orot  <= '0;
                            r_odeg  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_slot  <= '0;
                            r_state <= S_SCAN2;
                        end
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                S_SCAN2: begin
                    if (r_phase[r_slot] == tzrt_pkg::PH_RUN) begin
                        if (last_slot) begin
                            r_ov    <= 1'b1;
                            r_oslot <= '0;
                            r_okind <= tzrt_pkg::EV_NONE;
                            r_ozoom <= '0;
                            r_orot  <= '0;
                            r_odeg  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_slot <= r_slot + 1'b1;
                        end
                    end else if (!r_has1[r_slot]) begin
                        r_has1[r_slot]  <= 1'b1;
                        r_link1[r_slot] <= r_di;
                        r_ov    <= 1'b1;
                        r_oslot <= 3'(r_slot);
                        r_okind <= tzrt_pkg::EV_CLAIM;
                        r_ozoom <= r_zoom[r_slot];
                        r_orot  <= r_rot[r_slot];
                        r_odeg  <= r_degen[r_slot];
                        r_state <= S_IDLE;
                    end else if (r_link1[r_slot] != r_di) begin
                        r_state <= S_DRD;
                    end else begin
                        r_ov    <= 1'b1;
                        r_oslot <= '0;
                        r_okind <= tzrt_pkg::EV_NONE;
                        r_ozoom <= '0;
                        r_orot  <= '0;
                        r_odeg  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_DRD: begin
                    r_dv[2] <= $signed({1'b0, r_cx}) - $signed({1'b0, rb_cx});
                    r_dv[3] <= $signed({1'b0, r_cy}) - $signed({1'b0, rb_cy});
                    r_mt    <= '0;
                    r_sqi   <= 2'd2;
                    r_upd   <= 1'b0;
                    r_state <= S_SQM;
                end
                S_RDA: begin
                    r_pa    <= rd_data;
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_dv[0] <= $signed({1'b0, rb_sx}) - $signed({1'b0, ra_sx});
                    r_dv[1] <= $signed({1'b0, rb_sy}) - $signed({1'b0, ra_sy});
                    r_dv[2] <= $signed({1'b0, rb_cx}) - $signed({1'b0, ra_cx});
                    r_dv[3] <= $signed({1'b0, rb_cy}) - $signed({1'b0, ra_cy});
                    r_m0    <= '0;
                    r_mt    <= '0;
                    r_sqi   <= 2'd0;
                    r_upd   <= 1'b1;
                    r_state <= S_SQM;
                end
                S_SQM: begin
                    r_prod  <= sq_full[M_W-1:0];
                    r_state <= S_SQA;
                end
                S_SQA: begin
                    if (!r_sqi[1]) begin
                        r_m0 <= r_m0 + r_prod;
                    end else begin
                        r_mt <= acc_sum;
                    end
                    if (r_sqi == 2'd3) begin
                        if (!r_upd) begin
                            r_state <= S_DCMP;
                        end else if (r_m0 == '0) begin
                            r_nzoom <= '1;
                            r_ndeg  <= 1'b1;
                            r_state <= S_CST1;
                        end else begin
                            r_rem   <= '0;
                            r_quo   <= {acc_sum, 16'd0};
                            r_cnt   <= CNT_W'(Q_W - 1);
                            r_ndeg  <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_sqi   <= r_sqi + 2'd1;
                        r_state <= S_SQM;
                    end
                end
                S_DCMP: begin
                    if (64'(r_mt) < 64'(r_sep)) begin
                        r_has2[r_slot]  <= 1'b1;
                        r_link2[r_slot] <= r_di;
                        r_phase[r_slot] <= tzrt_pkg::PH_RUN;
                        r_ov    <= 1'b1;
                        r_oslot <= 3'(r_slot);
                        r_okind <= tzrt_pkg::EV_PAIR;
                        r_ozoom <= r_zoom[r_slot];
                        r_orot  <= r_rot[r_slot];
                        r_odeg  <= r_degen[r_slot];
                        r_state <= S_IDLE;
                    end else if (last_slot) begin
                        r_ov    <= 1'b1;
                        r_oslot <= '0;
                        r_okind <= tzrt_pkg::EV_NONE;
                        r_ozoom <= '0;
                        r_orot  <= '0;
                        r_odeg  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_SCAN2;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? M_W'(div_sh - {1'b0, r_m0}) : div_sh[M_W-1:0];
                    r_quo <= quo_next;
                    if (r_cnt == '0) begin
                        r_sqv   <= SQ_W'(quo_next);
                        r_root  <= '0;
                        r_srem  <= '0;
                        r_cnt   <= CNT_W'(R_W - 1);
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_SQRT: begin
                    r_srem <= sq_ge ? R_W'(sq_rem2 - sq_trial) : R_W'(sq_rem2);
                    r_root <= root_next;
                    r_sqv  <= {r_sqv[SQ_W-3:0], 2'b00};
                    if (r_cnt == '0) begin
                        r_nzoom <= (root_next > R_W'(65535)) ? '1 : root_next[ZW-1:0];
                        r_state <= S_CST1;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_CST1: begin
                    r_state <= S_CW1;
                end
                S_CW1: begin
                    if (cor_done) begin
                        r_at    <= cor_angle;
                        r_state <= S_CST0;
                    end
                end
                S_CST0: begin
                    r_state <= S_CW0;
                end
                S_CW0: begin
                    if (cor_done) begin
                        r_zoom[r_slot]  <= r_nzoom;
                        r_rot[r_slot]   <= rot_new;
                        r_degen[r_slot] <= r_ndeg;
                        r_ov    <= 1'b1;
                        r_oslot <= 3'(r_slot);
                        r_okind <= tzrt_pkg::EV_UPD;
                        r_ozoom <= r_nzoom;
                        r_orot  <= rot_new;
                        r_odeg  <= r_ndeg;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_ov;
    assign o_slot_index   = r_oslot;
    assign o_event_kind   = r_okind;
    assign o_zoom_value   = r_ozoom;
    assign o_rotate_value = r_orot;
    assign o_degenerate   = r_odeg;

endmodule

>>> hw/rtl/two_finger_zoom_rotate_tracker_top.sv
// ----------------------------------------------------------------------------
// two_finger_zoom_rotate_tracker_top
// Operation: a claim or end scans the slot table; each distance check reads a
//   stored position, squares the offsets and compares with the threshold; an
//   update runs the bit-serial divider, square root and two CORDIC passes.
// Flow: the back takes a new report only after the last one is finished;
//   a two-entry queue holds further reports.
// Reset: synchronous, active low; clears slot table and queue, threshold 40000.
// ----------------------------------------------------------------------------
module two_finger_zoom_rotate_tracker_top #(
    parameter int TOUCH_SLOTS = tzrt_pkg::TOUCH_SLOTS_DEF,
    parameter int COORD_BITS  = tzrt_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tzrt_pkg::DRAG_W-1:0]      i_drag_index,
    input  logic                             i_drag_ended,
    input  logic [COORD_BITS-1:0]            i_start_x,
    input  logic [COORD_BITS-1:0]            i_start_y,
    input  logic [COORD_BITS-1:0]            i_cur_x,
    input  logic [COORD_BITS-1:0]            i_cur_y,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tzrt_pkg::SEP_W-1:0]       i_cfg_data,
    output logic                             o_valid,
    output logic [2:0]                       o_slot_index,
    output logic [tzrt_pkg::KIND_W-1:0]      o_event_kind,
    output logic [tzrt_pkg::ZOOM_W-1:0]      o_zoom_value,
    output logic signed [tzrt_pkg::ROT_W-1:0] o_rotate_value,
    output logic                             o_degenerate
);

    localparam int POS_W  = 4 * COORD_BITS;
    localparam int ITEM_W = $bits(tzrt_pkg::t_cls) + POS_W;

    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    tzrt_pkg::t_cls    f_cls;
    logic [POS_W-1:0]  f_pos;
    tzrt_pkg::t_cls    q_cls;
    logic [POS_W-1:0]  q_pos;

    assign o_cfg_ready = 1'b1;

    tzrt_front #(
        .TOUCH_SLOTS (TOUCH_SLOTS),
        .COORD_BITS  (COORD_BITS)
    ) u_front (
        .i_start      (start),
        .o_busy       (busy),
        .i_drag_index (i_drag_index),
        .i_drag_ended (i_drag_ended),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_cur_x      (i_cur_x),
        .i_cur_y      (i_cur_y),
        .i_full       (full),
        .o_push       (push),
        .o_cls        (f_cls),
        .o_pos        (f_pos)
    );

    tzrt_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cls, f_pos}),
        .i_pop   (pop),
        .o_data  ({q_cls, q_pos}),
        .o_full  (full),
        .o_empty (empty)
    );

    tzrt_back #(
        .TOUCH_SLOTS (TOUCH_SLOTS),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_empty        (empty),
        .i_cls          (q_cls),
        .i_pos          (q_pos),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_slot_index   (o_slot_index),
        .o_event_kind   (o_event_kind),
        .o_zoom_value   (o_zoom_value),
        .o_rotate_value (o_rotate_value),
        .o_degenerate   (o_degenerate)
    );

endmodule

>>> hw/rtl/tzrt_checker.sv
// ----------------------------------------------------------------------------
// tzrt_checker
// Port-level checks on the result strobe and result fields of the tracker.
// ----------------------------------------------------------------------------
module tzrt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic [2:0]                        o_slot_index,
    input logic [tzrt_pkg::KIND_W-1:0]       o_event_kind,
    input logic [tzrt_pkg::ZOOM_W-1:0]       o_zoom_value,
    input logic signed [tzrt_pkg::ROT_W-1:0] o_rotate_value,
    input logic                              o_degenerate
);

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_event_kind == tzrt_pkg::EV_NONE || o_event_kind == tzrt_pkg::EV_UPD ||
                     o_event_kind == tzrt_pkg::EV_DONE || o_event_kind == tzrt_pkg::EV_CLAIM ||
                     o_event_kind == tzrt_pkg::EV_PAIR))
        else $error("illegal event kind");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind == tzrt_pkg::EV_NONE) |->
            (o_slot_index == 3'd0 && o_zoom_value == '0 &&
             o_rotate_value == '0 && !o_degenerate))
        else $error("nonzero fields on empty event");

    a_degen_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_zoom_value == 16'hFFFF))
        else $error("degenerate slot without saturated zoom");

endmodule

bind two_finger_zoom_rotate_tracker_top tzrt_checker u_tzrt_checker (.*);
